FILE: hdl/sha1md_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1md_pkg
// types, constants and controller commands shared by the sha-1 digest core
// ----------------------------------------------------------------------------
package sha1md_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int ROUNDS      = 80;

	// packed so that index i holds h_i
	localparam logic [4:0][31:0] SHA1_IV = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	// round constant for each group of twenty rounds
	localparam logic [3:0][31:0] SHA1_K = {
		32'hca62c1d6, 32'h8f1bbcdc, 32'h6ed9eba1, 32'h5a827999
	};

	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef enum logic [1:0] {
		PAD_MARK,
		PAD_ZERO,
		PAD_LEN
	} pad_kind_t;

	typedef enum logic [1:0] {
		PH_CH,
		PH_PARITY1,
		PH_MAJ,
		PH_PARITY2
	} round_phase_t;

	typedef struct packed {
		logic         push;
		logic         pad;
		pad_kind_t    kind;
		logic         load;
		logic         round;
		round_phase_t phase;
		logic         fold;
		logic         clear;
		logic [2:0]   word_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
	} dp_stat_t;

endpackage

FILE: hdl/sha1_message_digest_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// streaming sha-1 hash engine, byte in, five digest words out
// ----------------------------------------------------------------------------
// message bytes enter one item per cycle while a 64-byte block fills; the
// 64th byte starts the compression, which runs one round per cycle on a
// single round unit, so the input is held off for the 80 rounds and the
// chaining-value add of each block. after the item flagged last_byte the
// controller appends the 0x80 marker, zero fill and the 64-bit big-endian
// bit length one byte per cycle (9 to 72 bytes), compresses one or two
// more blocks, then offers the digest as five items h0..h4 on the output,
// the fifth flagged last_word. no new byte is taken until the fifth word
// is taken; the chaining value and the bit count (which wraps at 2^64)
// then return to their initial values and the next byte begins a new
// message.
// ----------------------------------------------------------------------------
module sha1_message_digest_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sha1md_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sha1md_pkg::out_item_t out_data
);
	import sha1md_pkg::*;

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [31:0] digest_word;
	logic [2:0]  word_index;

	// sequencer: intake, padding, round count, output word count
	sha1md_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.last_byte  (in_data.last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_index (word_index),
		.cmd        (cmd),
		.stat       (stat)
	);

	// schedule window, working variables, chaining value and bit count
	sha1md_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (in_data.data_byte),
		.cmd         (cmd),
		.stat        (stat),
		.digest_word (digest_word)
	);

	// digest words come straight from the held chaining value registers
	assign out_data.digest_word = digest_word;
	assign out_data.word_index  = word_index;
	assign out_data.last_word   = (word_index == 3'd4);

	// intake and digest output never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while digest item offered");

	// the final byte always leads into padding or compression
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_byte |=> !in_ready)
		else $error("input still ready after final byte");

	// after the last digest word the core is back to taking bytes
	a_back_to_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last_word |=> in_ready && !out_valid)
		else $error("core not back to intake after digest");

endmodule

FILE: hdl/sha1md_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1md_datapath
// byte packing, message schedule window, round registers and chaining value
// ----------------------------------------------------------------------------
module sha1md_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  sha1md_pkg::dp_cmd_t  cmd,
	output sha1md_pkg::dp_stat_t stat,
	output logic [31:0]        digest_word
);
	import sha1md_pkg::*;

	logic [4:0][31:0]  h_q;
	logic [4:0][31:0]  st_q;
	logic [15:0][31:0] w_q;
	logic [23:0]       acc_q;
	logic [63:0]       len_q;
	logic [5:0]        pos_q;

	logic [7:0]  pad_byte;
	logic [7:0]  byte_in;
	logic [31:0] f_val;
	logic [31:0] sched;
	logic [31:0] tmp;
	logic [31:0] a_rot;
	logic [31:0] b_rot;
	logic [2:0]  len_sel;

	// length bytes go out most significant first from position 56
	assign len_sel = ~pos_q[2:0];

	always_comb begin
		case (cmd.kind)
			PAD_MARK: pad_byte = PAD_MARK_BYTE;
			PAD_LEN:  pad_byte = len_q[{len_sel, 3'b000} +: 8];
			default:  pad_byte = 8'h00;
		endcase
	end

	assign byte_in = cmd.pad ? pad_byte : data_byte;

	always_comb begin
		case (cmd.phase)
			PH_CH:   f_val = (st_q[1] & st_q[2]) | (~st_q[1] & st_q[3]);
			PH_MAJ:  f_val = (st_q[1] & st_q[2]) | (st_q[1] & st_q[3]) | (st_q[2] & st_q[3]);
			default: f_val = st_q[1] ^ st_q[2] ^ st_q[3];
		endcase
	end

	assign sched = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign a_rot = {st_q[0][26:0], st_q[0][31:27]};
	assign b_rot = {st_q[1][1:0], st_q[1][31:2]};
	assign tmp   = a_rot + f_val + st_q[4] + SHA1_K[cmd.phase] + w_q[0];

	// chaining value, length and fill position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q   <= SHA1_IV;
			len_q <= '0;
			pos_q <= '0;
		end else if (cmd.clear) begin
			h_q   <= SHA1_IV;
			len_q <= '0;
			pos_q <= '0;
		end else begin
			if (cmd.push) begin
				pos_q <= pos_q + 6'd1;
				if (!cmd.pad)
					len_q <= len_q + 64'd8;
			end
			if (cmd.fold) begin
				for (int i = 0; i < 5; i++)
					h_q[i] <= h_q[i] + st_q[i];
			end
		end
	end

	// schedule window and working variables
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			acc_q <= {acc_q[15:0], byte_in};
			if (pos_q[1:0] == 2'd3)
				w_q <= {{acc_q, byte_in}, w_q[15:1]};
		end else if (cmd.round) begin
			w_q  <= {{sched[30:0], sched[31]}, w_q[15:1]};
			st_q <= {st_q[3], st_q[2], b_rot, st_q[0], tmp};
		end
		if (cmd.load)
			st_q <= h_q;
	end

	assign stat.pos    = pos_q;
	assign digest_word = h_q[cmd.word_sel];

endmodule

FILE: hdl/sha1md_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1md_ctrl
// sequencer for byte intake, padding, compression rounds and digest output
// ----------------------------------------------------------------------------
module sha1md_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           word_index,
	output sha1md_pkg::dp_cmd_t  cmd,
	input  sha1md_pkg::dp_stat_t stat
);
	import sha1md_pkg::*;

	typedef enum logic [2:0] {
		S_DATA,
		S_PAD,
		S_ROUND,
		S_FOLD,
		S_OUT
	} state_t;

	localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
	localparam logic [5:0] LAST_POS   = 6'(BLOCK_BYTES - 1);

	state_t     state_q;
	logic [6:0] rnd_q;
	logic [2:0] idx_q;
	logic       pad_q;
	logic       first_q;
	logic       len_blk_q;
	logic       done_q;

	logic in_acc;
	logic out_acc;
	logic blk_end;
	logic len_zone;

	assign in_ready   = (state_q == S_DATA);
	assign out_valid  = (state_q == S_OUT);
	assign in_acc     = in_valid & in_ready;
	assign out_acc    = out_valid & out_ready;
	assign blk_end    = (stat.pos == LAST_POS);
	assign len_zone   = (stat.pos[5:3] == 3'd7);
	assign word_index = idx_q;

	always_comb begin
		cmd          = '0;
		cmd.kind     = PAD_ZERO;
		cmd.phase    = PH_CH;
		cmd.word_sel = idx_q;
		case (state_q)
			S_DATA: begin
				cmd.push = in_acc;
				cmd.load = in_acc & blk_end;
			end
			S_PAD: begin
				cmd.push = 1'b1;
				cmd.pad  = 1'b1;
				cmd.load = blk_end;
				if (first_q)
					cmd.kind = PAD_MARK;
				else if (len_blk_q && len_zone)
					cmd.kind = PAD_LEN;
				else
					cmd.kind = PAD_ZERO;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (rnd_q < 7'd20)
					cmd.phase = PH_CH;
				else if (rnd_q < 7'd40)
					cmd.phase = PH_PARITY1;
				else if (rnd_q < 7'd60)
					cmd.phase = PH_MAJ;
				else
					cmd.phase = PH_PARITY2;
			end
			S_FOLD: begin
				cmd.fold = 1'b1;
			end
			S_OUT: begin
				cmd.clear = out_acc && (idx_q == 3'd4);
			end
			default: begin
				cmd.clear = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_DATA;
			rnd_q     <= '0;
			idx_q     <= '0;
			pad_q     <= 1'b0;
			first_q   <= 1'b0;
			len_blk_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			case (state_q)
				S_DATA: begin
					if (in_acc) begin
						if (last_byte) begin
							pad_q     <= 1'b1;
							first_q   <= 1'b1;
							len_blk_q <= 1'b0;
							done_q    <= 1'b0;
						end
						if (blk_end) begin
							rnd_q   <= '0;
							state_q <= S_ROUND;
						end else if (last_byte) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					first_q <= 1'b0;
					// marker lands early enough for the length to fit
					if (first_q && !len_zone)
						len_blk_q <= 1'b1;
					if (blk_end) begin
						if (len_blk_q)
							done_q <= 1'b1;
						else
							len_blk_q <= 1'b1;
						rnd_q   <= '0;
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_ROUND)
						state_q <= S_FOLD;
				end
				S_FOLD: begin
					if (done_q) begin
						idx_q   <= '0;
						state_q <= S_OUT;
					end else if (pad_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_DATA;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd4) begin
							idx_q   <= '0;
							pad_q   <= 1'b0;
							done_q  <= 1'b0;
							state_q <= S_DATA;
						end
					end
				end
				default: begin
					state_q <= S_DATA;
				end
			endcase
		end
	end

endmodule

FILE: tb/tb_sha1_message_digest_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_message_digest_core
// self-checking bench for the streaming sha-1 digest core
// ----------------------------------------------------------------------------
// bytes go in over a valid/ready channel and are absorbed by a bit-exact
// sha-1 model kept in the bench. every last_byte item queues the five
// digest words that the core must hand back, in order. a short table opens
// the run with the well-known "abc" vector typed in, single-byte messages
// at both ends of the byte range and back-to-back messages. random messages
// follow, with lengths around the block and padding boundaries, under three
// idle patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest_core;

	import sha1md_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LEN_POS     = 56;   // first byte of the bit length field
	localparam int DRAIN_WAIT  = 200;

	// the standard digest of the three-byte message "abc", h0 in the top word
	localparam logic [159:0] ABC_DIGEST =
		160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;
	localparam logic [159:0] NO_DIGEST = 160'h0;

	typedef struct packed {
		in_item_t     item;
		logic         has_digest;   // digest typed in below, else predicted
		logic [159:0] digest;
	} stim_row_t;

	localparam int N_ROWS = 12;
	localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
		// "abc" straight after reset checks the initial chaining value
		{8'h61, 1'b0, 1'b0, NO_DIGEST},
		{8'h62, 1'b0, 1'b0, NO_DIGEST},
		{8'h63, 1'b1, 1'b1, ABC_DIGEST},
		// one-byte messages at both ends of the byte range
		{8'hFF, 1'b1, 1'b0, NO_DIGEST},
		{8'h00, 1'b1, 1'b0, NO_DIGEST},
		// a short message with the marker value itself as data
		{8'h80, 1'b0, 1'b0, NO_DIGEST},
		{8'h00, 1'b0, 1'b0, NO_DIGEST},
		{8'hFF, 1'b0, 1'b0, NO_DIGEST},
		{8'h01, 1'b1, 1'b0, NO_DIGEST},
		// "abc" again: state must be back at its initial value after a digest
		{8'h61, 1'b0, 1'b0, NO_DIGEST},
		{8'h62, 1'b0, 1'b0, NO_DIGEST},
		{8'h63, 1'b1, 1'b1, ABC_DIGEST}
	};

	// message lengths that land on the padding and block boundaries
	localparam int N_BOUNDARY = 10;
	localparam int BOUNDARY_LENS [N_BOUNDARY] = '{
		55, 56, 57, 63, 64, 65, 119, 120, 127, 128
	};

	// one forced boundary message opens each idle phase: a full block on the
	// final byte, no room for the length, and the exact fit
	localparam int PHASE_FIRST_LEN [3] = '{64, 56, 55};
	localparam int PHASE_SEND_IDLE [3] = '{13, 80, 0};
	localparam int PHASE_RECV_IDLE [3] = '{80, 13, 0};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count   = 0;
	int cycle_count   = 0;

	// predictor state: chaining value, block under fill and the bit count
	logic [31:0] hash_state [5];
	logic [7:0]  fill_block [64];
	logic [63:0] msg_bit_count;

	// digest words still owed by the core, oldest first
	out_item_t digest_q [$];

	sha1_message_digest_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// 80-round compression of fill_block into hash_state
	task automatic compress_fill_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, sum;
		int          r;
		int          slot;
		for (r = 0; r < 16; r++)
			w[r] = {fill_block[4*r], fill_block[4*r+1], fill_block[4*r+2],
				fill_block[4*r+3]};
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (r = 0; r < ROUNDS; r++) begin
			slot = r % 16;
			// schedule window is circular, rewritten in place from round 16
			if (r >= 16)
				w[slot] = rotl(w[(r-3)%16] ^ w[(r-8)%16] ^ w[(r-14)%16] ^ w[slot], 1);
			case (round_phase_t'(r / 20))
				PH_CH:      f = (b & c) | (~b & d);
				PH_MAJ:     f = (b & c) | (b & d) | (c & d);
				default:    f = b ^ c ^ d;
			endcase
			sum = rotl(a, 5) + f + e + SHA1_K[r / 20] + w[slot];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = sum;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endtask

	task automatic reset_hash_state();
		int i;
		for (i = 0; i < 5; i++)
			hash_state[i] = SHA1_IV[i];
		msg_bit_count = '0;
	endtask

	// take one accepted byte; on the last byte pad, finish and queue the digest
	task automatic absorb_byte(input in_item_t it);
		int        pos;
		int        i;
		out_item_t word;
		pos = int'(msg_bit_count[8:3]);
		fill_block[pos] = it.data_byte;
		msg_bit_count += 64'd8;
		if (pos == BLOCK_BYTES - 1)
			compress_fill_block();
		if (it.last_byte) begin
			pos = int'(msg_bit_count[8:3]);
			fill_block[pos] = PAD_MARK_BYTE;
			pos = pos + 1;
			// no room for the length: zero the rest and spill into a second block
			if (pos > LEN_POS) begin
				while (pos < BLOCK_BYTES) begin
					fill_block[pos] = 8'h00;
					pos = pos + 1;
				end
				compress_fill_block();
				pos = 0;
			end
			while (pos < LEN_POS) begin
				fill_block[pos] = 8'h00;
				pos = pos + 1;
			end
			for (i = 0; i < 8; i++)
				fill_block[LEN_POS + i] = msg_bit_count[63 - 8*i -: 8];
			compress_fill_block();
			for (i = 0; i < 5; i++) begin
				word.digest_word = hash_state[i];
				word.word_index  = 3'(i);
				word.last_word   = (i == 4);
				digest_q.push_back(word);
			end
			reset_hash_state();
		end
	endtask

	// offer one item, with a random gap first, and hold it until taken
	task automatic send_byte(input in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		absorb_byte(it);
	endtask

	task automatic send_message(input int len);
		in_item_t it;
		int       j;
		for (j = 0; j < len; j++) begin
			it.data_byte = 8'($urandom_range(255));
			it.last_byte = (j == len - 1);
			send_byte(it);
		end
	endtask

	// receiver: random back-pressure, every taken item checked in order
	always @(posedge clk) begin : digest_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				$error("digest item with none expected: digest_word %h", out_data.digest_word);
				error_count++;
			end else begin
				want = digest_q.pop_front();
				if (out_data.digest_word !== want.digest_word) begin
					$error("digest_word expected %h actual %h",
						want.digest_word, out_data.digest_word);
					error_count++;
				end
				if (out_data.word_index !== want.word_index) begin
					$error("word_index expected %0d actual %0d",
						want.word_index, out_data.word_index);
					error_count++;
				end
				if (out_data.last_word !== want.last_word) begin
					$error("last_word expected %0b actual %0b",
						want.last_word, out_data.last_word);
					error_count++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int row;
		int ph;
		int i;
		int len;
		int phase_bytes;
		int phase_msgs;
		reset_hash_state();
		send_idle_pct = PHASE_SEND_IDLE[0];
		recv_idle_pct = PHASE_RECV_IDLE[0];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed table: rows with a typed digest overwrite the prediction
		for (row = 0; row < N_ROWS; row++) begin
			send_byte(DIRECTED_ROWS[row].item);
			if (DIRECTED_ROWS[row].has_digest)
				for (i = 0; i < 5; i++)
					digest_q[digest_q.size() - 5 + i].digest_word =
						DIRECTED_ROWS[row].digest[159 - 32*i -: 32];
		end

		// random messages: mostly short, an eighth on the boundary lengths
		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = PHASE_SEND_IDLE[ph];
			recv_idle_pct = PHASE_RECV_IDLE[ph];
			send_message(PHASE_FIRST_LEN[ph]);
			phase_bytes = PHASE_FIRST_LEN[ph];
			phase_msgs  = 1;
			while (phase_bytes < 66 || phase_msgs < 2) begin
				if ($urandom_range(7) == 0)
					len = BOUNDARY_LENS[$urandom_range(N_BOUNDARY - 1)];
				else
					len = $urandom_range(16, 1);
				send_message(len);
				phase_bytes += len;
				phase_msgs++;
			end
		end
		in_valid <= 1'b0;

		// let the owed digests drain, then watch a while for strays
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
